>>> hw/rtl/x25_call_request_parser_defines.svh
// assertion macros shared by the call request parser checks
`ifndef X25_CALL_REQUEST_PARSER_DEFINES_SVH
`define X25_CALL_REQUEST_PARSER_DEFINES_SVH

// same-cycle implication, sampled on clk, off while in reset
`define X25CRP_ASSERT_IMPL(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("x25crp check failed");

// next-cycle implication, sampled on clk, off while in reset
`define X25CRP_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("x25crp check failed");

`endif

>>> hw/rtl/x25crp_pkg.sv
// shared types and constants of the call request parser
package x25crp_pkg;

	// result item kinds
	localparam logic [2:0] KIND_CALLED_DIGIT  = 3'd0;
	localparam logic [2:0] KIND_CALLING_DIGIT = 3'd1;
	localparam logic [2:0] KIND_CALLED_YBTS   = 3'd2;
	localparam logic [2:0] KIND_CALLING_YBTS  = 3'd3;
	localparam logic [2:0] KIND_SUMMARY       = 3'd4;

	// summary status codes
	localparam logic [1:0] STATUS_OK        = 2'd0;
	localparam logic [1:0] STATUS_SHORT     = 2'd1;
	localparam logic [1:0] STATUS_NOT_CALL  = 2'd2;

	// fixed limits
	localparam logic [7:0] MAX_USER_DATA  = 8'd128;
	localparam logic [5:0] PROTO_ID_BYTES = 6'd4;

	// register reset values
	localparam logic [7:0]  RST_CALL_CODE   = 8'd11;
	localparam logic [31:0] RST_TERM_ID     = 32'h0100_0000;
	localparam logic [31:0] RST_TERM_MASK   = 32'hff00_0000;

	typedef struct packed {
		logic [7:0]  call_code;
		logic [31:0] term_id;
		logic [31:0] term_mask;
	} cfg_t;

	typedef struct packed {
		logic [2:0] kind;
		logic [7:0] value;
	} item_t;

	// everything one input byte produces: up to three items sharing the context fields
	typedef struct packed {
		logic [1:0]       count;
		item_t [2:0]      items;
		logic [11:0]      channel;
		logic [7:0]       ptype;
		logic [31:0]      proto;
		logic [7:0]       ud_count;
		logic             terminal;
		logic [1:0]       status;
	} bundle_t;

endpackage

>>> hw/rtl/x25crp_if.sv
// valid/ready channels for packet bytes and result items

interface x25crp_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       end_of_packet;

	modport source (output valid, data_byte, end_of_packet, input ready);
	modport sink (input valid, data_byte, end_of_packet, output ready);
endinterface

interface x25crp_item_if;
	logic        valid;
	logic        ready;
	logic [2:0]  item_kind;
	logic [7:0]  item_value;
	logic [11:0] channel_number;
	logic [7:0]  packet_kind;
	logic [31:0] protocol_id;
	logic [7:0]  user_data_count;
	logic        is_terminal_call;
	logic [1:0]  parse_status;
	logic        last_item;

	modport source (
		output valid, item_kind, item_value, channel_number, packet_kind, protocol_id,
			user_data_count, is_terminal_call, parse_status, last_item,
		input ready
	);
	modport sink (
		input valid, item_kind, item_value, channel_number, packet_kind, protocol_id,
			user_data_count, is_terminal_call, parse_status, last_item,
		output ready
	);
endinterface

>>> hw/rtl/x25crp_core.sv
// per-byte parse state and the item bundle each byte produces
module x25crp_core
	import x25crp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       accept,
	input  logic [7:0] data_byte,
	input  logic       end_of_packet,
	input  cfg_t       cfg,
	output bundle_t    bundle
);

	localparam logic [3:0] PH_HDR   = 4'd0;
	localparam logic [3:0] PH_ALEN  = 4'd1;
	localparam logic [3:0] PH_DIG   = 4'd2;
	localparam logic [3:0] PH_FLEN  = 4'd3;
	localparam logic [3:0] PH_FSKIP = 4'd4;
	localparam logic [3:0] PH_PROTO = 4'd5;
	localparam logic [3:0] PH_YLEN1 = 4'd6;
	localparam logic [3:0] PH_YSTR1 = 4'd7;
	localparam logic [3:0] PH_YLEN2 = 4'd8;
	localparam logic [3:0] PH_YSTR2 = 4'd9;
	localparam logic [3:0] PH_REST  = 4'd10;

	logic [3:0]  phase_q, phase_n;
	logic [1:0]  hidx_q, hidx_n;
	logic [3:0]  called_len_q, called_len_n;
	logic [3:0]  calling_len_q, calling_len_n;
	logic [4:0]  dpos_q, dpos_n;
	logic [5:0]  frem_q, frem_n;
	logic [7:0]  ud_q, ud_n;
	logic [31:0] proto_q, proto_n;
	logic [11:0] chan_q, chan_n;
	logic [7:0]  type_q, type_n;
	logic        stop_q, stop_n;

	function automatic logic [7:0] to_lower(input logic [7:0] c);
		logic [7:0] r;
		r = c;
		if (c >= 8'h41 && c <= 8'h5a) begin
			r = c + 8'h20;
		end
		return r;
	endfunction

	// one parse step
	always_comb begin
		logic [4:0]  total;
		logic [4:0]  pos;
		logic [1:0]  k;
		logic        type_ok;
		item_t [2:0] items;
		logic [1:0]  status;

		phase_n       = phase_q;
		hidx_n        = hidx_q;
		called_len_n  = called_len_q;
		calling_len_n = calling_len_q;
		dpos_n        = dpos_q;
		frem_n        = frem_q;
		ud_n          = ud_q;
		proto_n       = proto_q;
		chan_n        = chan_q;
		type_n        = type_q;
		stop_n        = stop_q;
		total         = {1'b0, called_len_q} + {1'b0, calling_len_q};
		pos           = dpos_q;
		k             = 2'd0;
		items         = '0;
		status        = STATUS_OK;

		// user data counter, saturating
		if (phase_q >= PH_PROTO && ud_q < MAX_USER_DATA) begin
			ud_n = ud_q + 8'd1;
		end

		unique case (phase_q)
			PH_HDR: begin
				if (hidx_q == 2'd0) begin
					chan_n = {data_byte[3:0], 8'h00};
					hidx_n = 2'd1;
				end else if (hidx_q == 2'd1) begin
					chan_n = {chan_q[11:8], data_byte};
					hidx_n = 2'd2;
				end else begin
					type_n  = data_byte;
					hidx_n  = 2'd0;
					phase_n = PH_ALEN;
				end
			end
			PH_ALEN: begin
				called_len_n  = data_byte[3:0];
				calling_len_n = data_byte[7:4];
				dpos_n        = 5'd0;
				phase_n       = (data_byte != 8'h00) ? PH_DIG : PH_FLEN;
			end
			PH_DIG: begin
				// high nibble first, then low nibble
				if (pos < {1'b0, called_len_q}) begin
					items[k] = '{kind: KIND_CALLED_DIGIT, value: {4'h0, data_byte[7:4]}};
					k        = k + 2'd1;
					pos      = pos + 5'd1;
				end else if (pos < total) begin
					items[k] = '{kind: KIND_CALLING_DIGIT, value: {4'h0, data_byte[7:4]}};
					k        = k + 2'd1;
					pos      = pos + 5'd1;
				end
				if (pos < {1'b0, called_len_q}) begin
					items[k] = '{kind: KIND_CALLED_DIGIT, value: {4'h0, data_byte[3:0]}};
					k        = k + 2'd1;
					pos      = pos + 5'd1;
				end else if (pos < total) begin
					items[k] = '{kind: KIND_CALLING_DIGIT, value: {4'h0, data_byte[3:0]}};
					k        = k + 2'd1;
					pos      = pos + 5'd1;
				end
				dpos_n = pos;
				if (pos >= total) begin
					phase_n = PH_FLEN;
				end
			end
			PH_FLEN: begin
				frem_n  = data_byte[5:0];
				phase_n = (data_byte[5:0] != 6'd0) ? PH_FSKIP : PH_PROTO;
			end
			PH_FSKIP: begin
				frem_n = frem_q - 6'd1;
				if (frem_n == 6'd0) begin
					phase_n = PH_PROTO;
				end
			end
			PH_PROTO: begin
				proto_n = {proto_q[23:0], data_byte};
				frem_n  = frem_q + 6'd1;
				if (frem_n >= PROTO_ID_BYTES) begin
					frem_n  = 6'd0;
					phase_n = (type_q == 8'h00 || type_q == cfg.call_code) ? PH_YLEN1 : PH_REST;
				end
			end
			PH_YLEN1, PH_YLEN2: begin
				if (!data_byte[7]) begin
					phase_n = PH_REST;
				end else begin
					frem_n = data_byte[5:0];
					stop_n = 1'b0;
					if (data_byte[5:0] != 6'd0) begin
						phase_n = (phase_q == PH_YLEN1) ? PH_YSTR1 : PH_YSTR2;
					end else begin
						phase_n = (phase_q == PH_YLEN1) ? PH_YLEN2 : PH_REST;
					end
				end
			end
			PH_YSTR1, PH_YSTR2: begin
				// a zero byte ends the visible part of the string
				if (data_byte == 8'h00) begin
					stop_n = 1'b1;
				end
				if (!stop_n) begin
					items[k].kind  = (phase_q == PH_YSTR1) ? KIND_CALLED_YBTS : KIND_CALLING_YBTS;
					items[k].value = to_lower(data_byte);
					k              = k + 2'd1;
				end
				frem_n = frem_q - 6'd1;
				if (frem_n == 6'd0) begin
					phase_n = (phase_q == PH_YSTR1) ? PH_YLEN2 : PH_REST;
				end
			end
			default: begin
				phase_n = PH_REST;
			end
		endcase

		// summary on the last byte
		type_ok = (type_n == 8'h00) || (type_n == cfg.call_code);
		if (end_of_packet) begin
			if (phase_n == PH_HDR) begin
				status = STATUS_SHORT;
			end else if (!type_ok) begin
				status = STATUS_NOT_CALL;
			end else if (phase_n < PH_PROTO) begin
				status = STATUS_SHORT;
			end else begin
				status = STATUS_OK;
			end
			items[k] = '{kind: KIND_SUMMARY, value: 8'h00};
			k        = k + 2'd1;
		end

		bundle.count    = k;
		bundle.items    = items;
		bundle.channel  = chan_n;
		bundle.ptype    = type_n;
		bundle.proto    = proto_n;
		bundle.ud_count = ud_n;
		bundle.terminal = ((proto_n & cfg.term_mask) == cfg.term_id);
		bundle.status   = status;
	end

	// parse state, cleared at the end of each packet
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_HDR;
			hidx_q        <= 2'd0;
			called_len_q  <= 4'd0;
			calling_len_q <= 4'd0;
			dpos_q        <= 5'd0;
			frem_q        <= 6'd0;
			ud_q          <= 8'd0;
			proto_q       <= 32'd0;
			chan_q        <= 12'd0;
			type_q        <= 8'd0;
			stop_q        <= 1'b0;
		end else if (accept) begin
			if (end_of_packet) begin
				phase_q       <= PH_HDR;
				hidx_q        <= 2'd0;
				called_len_q  <= 4'd0;
				calling_len_q <= 4'd0;
				dpos_q        <= 5'd0;
				frem_q        <= 6'd0;
				ud_q          <= 8'd0;
				proto_q       <= 32'd0;
				chan_q        <= 12'd0;
				type_q        <= 8'd0;
				stop_q        <= 1'b0;
			end else begin
				phase_q       <= phase_n;
				hidx_q        <= hidx_n;
				called_len_q  <= called_len_n;
				calling_len_q <= calling_len_n;
				dpos_q        <= dpos_n;
				frem_q        <= frem_n;
				ud_q          <= ud_n;
				proto_q       <= proto_n;
				chan_q        <= chan_n;
				type_q        <= type_n;
				stop_q        <= stop_n;
			end
		end
	end

endmodule

>>> hw/rtl/x25_call_request_parser.sv
// X.25 call request parser: packet bytes in, address digits, YBTS characters and a summary out
//
// Takes one packet byte per transfer on pkt and returns result items on res, one per
// transfer. Each byte is parsed in the cycle it is taken; its zero to three items
// (address digits, YBTS characters, and the summary on the byte marked end_of_packet)
// sit in a bundle register and leave through an output register onto res. Bytes that give
// at most one item go through at one per cycle while res does not stall; a byte that gives
// more items holds pkt until its last item is popped, set by the single item per cycle of
// the res port. The APB registers (call request code at 0x0, terminal protocol id at 0x4,
// its mask at 0x8) reset to 11, 0x01000000 and 0xff000000 and are to be written by the user
// only while no packet is in flight; the block itself does not enforce this.
module x25_call_request_parser
	import x25crp_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	x25crp_byte_if.sink          pkt,
	x25crp_item_if.source        res,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [3:0]           paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready
);

	localparam logic [1:0] REG_CALL_CODE  = 2'd0;
	localparam logic [1:0] REG_TERM_ID    = 2'd1;
	localparam logic [1:0] REG_TERM_MASK  = 2'd2;

	cfg_t       cfg_q;
	bundle_t    bundle;
	bundle_t    bnd_s1;
	logic       bnd_valid_s1;
	logic [1:0] idx_q;
	logic       pop;
	logic       pop_last;
	logic       accept;
	item_t      slot;

	logic        out_valid_q;
	logic [2:0]  out_kind_q;
	logic [7:0]  out_value_q;
	logic [11:0] out_chan_q;
	logic [7:0]  out_type_q;
	logic [31:0] out_proto_q;
	logic [7:0]  out_ud_q;
	logic        out_term_q;
	logic [1:0]  out_status_q;

	// configuration registers
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.call_code <= RST_CALL_CODE;
			cfg_q.term_id   <= RST_TERM_ID;
			cfg_q.term_mask <= RST_TERM_MASK;
		end else if (psel && penable && pwrite && pready) begin
			unique case (paddr[3:2])
				REG_CALL_CODE: cfg_q.call_code <= pwdata[7:0];
				REG_TERM_ID:   cfg_q.term_id   <= pwdata;
				REG_TERM_MASK: cfg_q.term_mask <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_CALL_CODE: prdata = {24'h000000, cfg_q.call_code};
			REG_TERM_ID:   prdata = cfg_q.term_id;
			REG_TERM_MASK: prdata = cfg_q.term_mask;
			default:       prdata = 32'h0000_0000;
		endcase
	end

	// handshake between bundle and output register
	assign pop      = bnd_valid_s1 && (!out_valid_q || res.ready);
	assign pop_last = pop && (idx_q == bnd_s1.count - 2'd1);
	assign pkt.ready = !bnd_valid_s1 || pop_last;
	assign accept   = pkt.valid && pkt.ready;
	assign slot     = bnd_s1.items[idx_q];

	x25crp_core u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (accept),
		.data_byte     (pkt.data_byte),
		.end_of_packet (pkt.end_of_packet),
		.cfg           (cfg_q),
		.bundle        (bundle)
	);

	// bundle register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bnd_valid_s1 <= 1'b0;
			idx_q        <= 2'd0;
		end else if (accept && bundle.count != 2'd0) begin
			bnd_valid_s1 <= 1'b1;
			idx_q        <= 2'd0;
		end else if (pop_last) begin
			bnd_valid_s1 <= 1'b0;
			idx_q        <= 2'd0;
		end else if (pop) begin
			idx_q <= idx_q + 2'd1;
		end
	end

	// bundle payload
	always_ff @(posedge clk) begin
		if (accept) begin
			bnd_s1 <= bundle;
		end
	end

	// output register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (pop) begin
			out_kind_q   <= slot.kind;
			out_value_q  <= slot.value;
			out_chan_q   <= bnd_s1.channel;
			out_type_q   <= bnd_s1.ptype;
			out_proto_q  <= bnd_s1.proto;
			out_ud_q     <= bnd_s1.ud_count;
			out_term_q   <= bnd_s1.terminal;
			out_status_q <= (slot.kind == KIND_SUMMARY) ? bnd_s1.status : STATUS_OK;
		end
	end

	assign res.valid            = out_valid_q;
	assign res.item_kind        = out_kind_q;
	assign res.item_value       = out_value_q;
	assign res.channel_number   = out_chan_q;
	assign res.packet_kind      = out_type_q;
	assign res.protocol_id      = out_proto_q;
	assign res.user_data_count  = out_ud_q;
	assign res.is_terminal_call = out_term_q;
	assign res.parse_status     = out_status_q;
	assign res.last_item        = (out_kind_q == KIND_SUMMARY);

endmodule

>>> hw/rtl/x25crp_chk.sv
// port-level checks of the call request parser and their binding
`include "x25_call_request_parser_defines.svh"

module x25crp_chk
	import x25crp_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        res_valid,
	input logic        res_ready,
	input logic [2:0]  res_kind,
	input logic [7:0]  res_value,
	input logic [31:0] res_proto,
	input logic [7:0]  res_ud,
	input logic [1:0]  res_status,
	input logic        res_last
);

	// a stalled result keeps its payload
	`X25CRP_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(res_kind) && $stable(res_value) && $stable(res_proto) && $stable(res_status))

	// only the summary carries a status
	`X25CRP_ASSERT_IMPL(a_status_summary, res_valid && !res_last, res_status == STATUS_OK)

	// address digits are single nibbles
	`X25CRP_ASSERT_IMPL(a_digit_nibble, res_valid && (res_kind == KIND_CALLED_DIGIT || res_kind == KIND_CALLING_DIGIT), res_value[7:4] == 4'h0)

	// user data count saturates
	`X25CRP_ASSERT_IMPL(a_ud_bound, res_valid, res_ud <= MAX_USER_DATA)

endmodule

bind x25_call_request_parser x25crp_chk u_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.res_valid  (res.valid),
	.res_ready  (res.ready),
	.res_kind   (res.item_kind),
	.res_value  (res.item_value),
	.res_proto  (res.protocol_id),
	.res_ud     (res.user_data_count),
	.res_status (res.parse_status),
	.res_last   (res.last_item)
);

>>> tb/x25_call_request_parser_test.sv
// self-checking testbench of the call request parser with its own byte-level predictor
`timescale 1ns / 1ps

module x25_call_request_parser_test;
	import x25crp_pkg::*;

	// register byte addresses
	localparam logic [3:0] REG_CALL_CODE = 4'h0;
	localparam logic [3:0] REG_TERM_ID   = 4'h4;
	localparam logic [3:0] REG_TERM_MASK = 4'h8;

	localparam int IDLE_LIMIT   = 4000;
	localparam int DRAIN_CYCLES = 8;
	localparam int HOLD_CYCLES  = 400;
	localparam int PHASE_ITEMS  = 45;

	typedef enum logic [3:0] {
		ST_HEADER, ST_ADDR_LEN, ST_DIGITS, ST_FAC_LEN, ST_FAC_SKIP, ST_PROTO,
		ST_YLEN_CALLED, ST_YSTR_CALLED, ST_YLEN_CALLING, ST_YSTR_CALLING, ST_REST
	} parse_phase_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [7:0]  value;
		logic [11:0] channel;
		logic [7:0]  ptype;
		logic [31:0] proto;
		logic [7:0]  ud_count;
		logic        terminal;
		logic [1:0]  status;
		logic        last;
	} result_t;

	typedef struct packed {
		logic [7:0] data;
		logic       eop;
		logic       known;
		logic [1:0] status;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic psel, penable, pwrite, pready;
	logic [3:0] paddr;
	logic [31:0] pwdata, prdata;

	x25crp_byte_if pkt_ch ();
	x25crp_item_if res_ch ();

	x25_call_request_parser uut (
		.clk(clk), .arst_n(arst_n), .pkt(pkt_ch), .res(res_ch),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// predicted register copies and parse state
	logic [7:0]   cfg_call_code;
	logic [31:0]  cfg_term_id;
	logic [31:0]  cfg_term_mask;
	parse_phase_t cur_phase;
	logic [1:0]   hdr_idx;
	logic [3:0]   called_len, calling_len;
	logic [4:0]   digit_pos;
	logic [5:0]   field_rem;
	logic [7:0]   ud_seen;
	logic [31:0]  proto_acc;
	logic [11:0]  channel_acc;
	logic [7:0]   type_acc;
	logic         str_stop;

	result_t    expected_items [$];
	logic [7:0] packet_bytes [$];
	int fail_count = 0;
	int sent_count = 0;
	int burst_left = 0;
	bit gaps_on = 1'b1;
	int holds_asked = 0;

	// directed packets: lone header byte, bad type, full call request, cut in facilities
	stim_row_t directed_rows [25] = '{
		'{8'h00, 1'b1, 1'b1, STATUS_SHORT},
		'{8'hff, 1'b0, 1'b0, STATUS_OK},
		'{8'hff, 1'b0, 1'b0, STATUS_OK},
		'{8'hff, 1'b1, 1'b1, STATUS_NOT_CALL},
		'{8'h5a, 1'b0, 1'b0, STATUS_OK},
		'{8'h3c, 1'b0, 1'b0, STATUS_OK},
		'{8'h0b, 1'b0, 1'b0, STATUS_OK},
		'{8'h21, 1'b0, 1'b0, STATUS_OK},
		'{8'h95, 1'b0, 1'b0, STATUS_OK},
		'{8'h30, 1'b0, 1'b0, STATUS_OK},
		'{8'h41, 1'b0, 1'b0, STATUS_OK},
		'{8'haa, 1'b0, 1'b0, STATUS_OK},
		'{8'h01, 1'b0, 1'b0, STATUS_OK},
		'{8'h00, 1'b0, 1'b0, STATUS_OK},
		'{8'h00, 1'b0, 1'b0, STATUS_OK},
		'{8'h00, 1'b0, 1'b0, STATUS_OK},
		'{8'h82, 1'b0, 1'b0, STATUS_OK},
		'{8'h51, 1'b0, 1'b0, STATUS_OK},
		'{8'h00, 1'b0, 1'b0, STATUS_OK},
		'{8'h01, 1'b1, 1'b1, STATUS_OK},
		'{8'h00, 1'b0, 1'b0, STATUS_OK},
		'{8'h00, 1'b0, 1'b0, STATUS_OK},
		'{8'h00, 1'b0, 1'b0, STATUS_OK},
		'{8'h00, 1'b0, 1'b0, STATUS_OK},
		'{8'h3f, 1'b1, 1'b1, STATUS_SHORT}
	};

	function automatic void clear_packet();
		cur_phase = ST_HEADER;
		hdr_idx = '0;
		called_len = '0;
		calling_len = '0;
		digit_pos = '0;
		field_rem = '0;
		ud_seen = '0;
		proto_acc = '0;
		channel_acc = '0;
		type_acc = '0;
		str_stop = 1'b0;
	endfunction

	function automatic bit type_ok();
		return (type_acc == 8'd0) || (type_acc == cfg_call_code);
	endfunction

	function automatic void queue_result(logic [2:0] kind, logic [7:0] value,
			logic [1:0] status, logic last);
		result_t r;
		r.kind = kind;
		r.value = value;
		r.channel = channel_acc;
		r.ptype = type_acc;
		r.proto = proto_acc;
		r.ud_count = ud_seen;
		r.terminal = ((proto_acc & cfg_term_mask) == cfg_term_id);
		r.status = status;
		r.last = last;
		expected_items.push_back(r);
	endfunction

	// called digits first, then calling digits, nothing past the total
	function automatic void emit_digit(logic [3:0] nib);
		if (int'(digit_pos) < int'(called_len)) begin
			queue_result(KIND_CALLED_DIGIT, {4'h0, nib}, STATUS_OK, 1'b0);
			digit_pos = digit_pos + 5'd1;
		end else if (int'(digit_pos) < int'(called_len) + int'(calling_len)) begin
			queue_result(KIND_CALLING_DIGIT, {4'h0, nib}, STATUS_OK, 1'b0);
			digit_pos = digit_pos + 5'd1;
		end
	endfunction

	// ybts length byte: no mark drops into plain user data
	function automatic parse_phase_t ybts_length(logic [7:0] b, parse_phase_t str_ph,
			parse_phase_t after);
		if (!b[7])
			return ST_REST;
		field_rem = b[5:0];
		str_stop = 1'b0;
		return (field_rem != 6'd0) ? str_ph : after;
	endfunction

	// advance the parse state by one accepted byte and queue what it yields
	function automatic void predict_byte(logic [7:0] b, logic eop);
		parse_phase_t p;
		logic [1:0] st;
		logic [7:0] ch;
		p = cur_phase;
		if (p >= ST_PROTO && ud_seen < MAX_USER_DATA)
			ud_seen = ud_seen + 8'd1;
		case (p)
			ST_HEADER: begin
				if (hdr_idx == 2'd0) begin
					channel_acc = {b[3:0], 8'h00};
					hdr_idx = 2'd1;
				end else if (hdr_idx == 2'd1) begin
					channel_acc = {channel_acc[11:8], b};
					hdr_idx = 2'd2;
				end else begin
					type_acc = b;
					hdr_idx = 2'd0;
					cur_phase = ST_ADDR_LEN;
				end
			end
			ST_ADDR_LEN: begin
				called_len = b[3:0];
				calling_len = b[7:4];
				digit_pos = '0;
				cur_phase = (b != 8'd0) ? ST_DIGITS : ST_FAC_LEN;
			end
			ST_DIGITS: begin
				emit_digit(b[7:4]);
				emit_digit(b[3:0]);
				if (int'(digit_pos) >= int'(called_len) + int'(calling_len))
					cur_phase = ST_FAC_LEN;
			end
			ST_FAC_LEN: begin
				field_rem = b[5:0];
				cur_phase = (field_rem != 6'd0) ? ST_FAC_SKIP : ST_PROTO;
			end
			ST_FAC_SKIP: begin
				field_rem = field_rem - 6'd1;
				if (field_rem == 6'd0)
					cur_phase = ST_PROTO;
			end
			ST_PROTO: begin
				proto_acc = {proto_acc[23:0], b};
				field_rem = field_rem + 6'd1;
				if (field_rem >= PROTO_ID_BYTES) begin
					field_rem = '0;
					cur_phase = type_ok() ? ST_YLEN_CALLED : ST_REST;
				end
			end
			ST_YLEN_CALLED: cur_phase = ybts_length(b, ST_YSTR_CALLED, ST_YLEN_CALLING);
			ST_YLEN_CALLING: cur_phase = ybts_length(b, ST_YSTR_CALLING, ST_REST);
			ST_YSTR_CALLED, ST_YSTR_CALLING: begin
				if (b == 8'd0)
					str_stop = 1'b1;
				ch = (b >= 8'h41 && b <= 8'h5a) ? b + 8'h20 : b;
				if (!str_stop)
					queue_result((p == ST_YSTR_CALLED) ? KIND_CALLED_YBTS : KIND_CALLING_YBTS,
						ch, STATUS_OK, 1'b0);
				field_rem = field_rem - 6'd1;
				if (field_rem == 6'd0)
					cur_phase = (p == ST_YSTR_CALLED) ? ST_YLEN_CALLING : ST_REST;
			end
			default: cur_phase = ST_REST;
		endcase
		if (eop) begin
			if (cur_phase == ST_HEADER)
				st = STATUS_SHORT;
			else if (!type_ok())
				st = STATUS_NOT_CALL;
			else if (cur_phase < ST_PROTO)
				st = STATUS_SHORT;
			else
				st = STATUS_OK;
			queue_result(KIND_SUMMARY, 8'h00, st, 1'b1);
			clear_packet();
		end
	endfunction

	// one byte transfer on pkt, with burst and gap shaping
	task automatic send_byte(input logic [7:0] b, input logic eop);
		int gap;
		if (gaps_on && burst_left == 0) begin
			gap = $urandom_range(0, 6);
			if (gap > 0) begin
				pkt_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 12);
		end
		pkt_ch.valid <= 1'b1;
		pkt_ch.data_byte <= b;
		pkt_ch.end_of_packet <= eop;
		@(posedge clk);
		while (!pkt_ch.ready)
			@(posedge clk);
		predict_byte(b, eop);
		sent_count++;
		if (burst_left > 0)
			burst_left--;
	endtask

	task automatic send_packet();
		foreach (packet_bytes[i])
			send_byte(packet_bytes[i], i == packet_bytes.size() - 1);
	endtask

	// sender pauses until every predicted item is out, then a short drain
	task automatic wait_idle();
		pkt_ch.valid <= 1'b0;
		while (expected_items.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic note_failure(input string msg);
		fail_count++;
		if (fail_count <= 10)
			$display("%s", msg);
	endtask

	task automatic show_result(input string tag, input result_t r);
		if (fail_count <= 10)
			$display("  %s kind=%0d value=%02h chan=%03h type=%02h proto=%08h ud=%0d term=%0b status=%0d last=%0b",
				tag, r.kind, r.value, r.channel, r.ptype, r.proto, r.ud_count, r.terminal,
				r.status, r.last);
	endtask

	// apb write: setup cycle then access cycle, then back to idle
	task automatic cfg_write(input logic [3:0] addr, input logic [31:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	// apb read back and compare
	task automatic cfg_check(input logic [3:0] addr, input logic [31:0] want);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= addr;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		if (prdata !== want)
			note_failure($sformatf("register %h read %08h, want %08h", addr, prdata, want));
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic apply_settings(input int ph);
		logic [7:0] code;
		logic [31:0] id, mask;
		code = 8'($urandom_range(0, 255));
		mask = $urandom;
		id = $urandom & mask;
		case (ph)
			1: begin
				code = 8'hff;
				id = 32'h0;
				mask = 32'h0;
			end
			2: begin
				code = 8'h00;
				id = 32'hffff_ffff;
				mask = 32'hffff_ffff;
			end
			4: begin
				code = RST_CALL_CODE;
				id = RST_TERM_ID;
				mask = RST_TERM_MASK;
			end
			6: begin
				mask = 32'h00ff_00ff;
				id = $urandom & mask;
			end
			default: ;
		endcase
		cfg_write(REG_CALL_CODE, {24'h0, code});
		cfg_write(REG_TERM_ID, id);
		cfg_write(REG_TERM_MASK, mask);
		cfg_call_code = code;
		cfg_term_id = id;
		cfg_term_mask = mask;
		cfg_check(REG_CALL_CODE, {24'h0, code});
		cfg_check(REG_TERM_ID, id);
		cfg_check(REG_TERM_MASK, mask);
	endtask

	// ybts string: mostly marked, short, mixed case, some zeros and case boundaries
	task automatic add_ybts();
		int r, len;
		logic [7:0] c;
		r = $urandom_range(0, 99);
		if (r < 12) begin
			packet_bytes.push_back(8'($urandom_range(0, 127)));
		end else begin
			len = (r < 20) ? $urandom_range(0, 63) : $urandom_range(0, 6);
			packet_bytes.push_back({1'b1, 1'($urandom_range(0, 1)), 6'(len)});
			repeat (len) begin
				case ($urandom_range(0, 9))
					0, 1, 2: c = 8'h41 + 8'($urandom_range(0, 25));
					3, 4: c = 8'h61 + 8'($urandom_range(0, 25));
					5: c = 8'h30 + 8'($urandom_range(0, 9));
					6: c = ($urandom_range(0, 2) == 0) ? 8'h00 : 8'($urandom_range(1, 255));
					7: begin
						case ($urandom_range(0, 3))
							0: c = 8'h40;
							1: c = 8'h41;
							2: c = 8'h5a;
							default: c = 8'h5b;
						endcase
					end
					default: c = 8'($urandom_range(0, 255));
				endcase
				packet_bytes.push_back(c);
			end
		end
	endtask

	// random call request: mostly well formed, some cut short, some pure noise
	task automatic build_packet(input bit long_tail);
		int r, ncalled, ncalling, nfac, ntail, cut;
		logic [31:0] proto;
		packet_bytes.delete();
		r = $urandom_range(0, 99);
		if (r < 8) begin
			repeat ($urandom_range(1, 10))
				packet_bytes.push_back(8'($urandom_range(0, 255)));
		end else begin
			packet_bytes.push_back(8'($urandom_range(0, 255)));
			packet_bytes.push_back(8'($urandom_range(0, 255)));
			r = $urandom_range(0, 99);
			if (r < 65)
				packet_bytes.push_back(cfg_call_code);
			else if (r < 80)
				packet_bytes.push_back(8'h00);
			else
				packet_bytes.push_back(8'($urandom_range(0, 255)));
			if ($urandom_range(0, 9) < 3) begin
				ncalled = $urandom_range(0, 15);
				ncalling = $urandom_range(0, 15);
			end else begin
				ncalled = $urandom_range(0, 6);
				ncalling = $urandom_range(0, 6);
			end
			packet_bytes.push_back({4'(ncalling), 4'(ncalled)});
			repeat ((ncalled + ncalling + 1) / 2)
				packet_bytes.push_back(8'($urandom_range(0, 255)));
			r = $urandom_range(0, 99);
			nfac = (r < 70) ? $urandom_range(0, 4) :
				(r < 95) ? $urandom_range(5, 20) : $urandom_range(21, 63);
			packet_bytes.push_back({2'($urandom_range(0, 3)), 6'(nfac)});
			repeat (nfac)
				packet_bytes.push_back(8'($urandom_range(0, 255)));
			proto = $urandom;
			if ($urandom_range(0, 9) < 4)
				proto = (proto & ~cfg_term_mask) | (cfg_term_id & cfg_term_mask);
			packet_bytes.push_back(proto[31:24]);
			packet_bytes.push_back(proto[23:16]);
			packet_bytes.push_back(proto[15:8]);
			packet_bytes.push_back(proto[7:0]);
			add_ybts();
			add_ybts();
			ntail = long_tail ? $urandom_range(130, 140) : $urandom_range(0, 3);
			repeat (ntail)
				packet_bytes.push_back(8'($urandom_range(0, 255)));
			if ($urandom_range(0, 99) < 12) begin
				cut = $urandom_range(1, packet_bytes.size());
				while (packet_bytes.size() > cut)
					void'(packet_bytes.pop_back());
			end
		end
	endtask

	// result checker against the oldest predicted item
	always @(posedge clk) begin : result_check
		result_t got, want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			got.kind = res_ch.item_kind;
			got.value = res_ch.item_value;
			got.channel = res_ch.channel_number;
			got.ptype = res_ch.packet_kind;
			got.proto = res_ch.protocol_id;
			got.ud_count = res_ch.user_data_count;
			got.terminal = res_ch.is_terminal_call;
			got.status = res_ch.parse_status;
			got.last = res_ch.last_item;
			if (expected_items.size() == 0) begin
				note_failure("result item with nothing predicted");
				show_result("got ", got);
			end else begin
				want = expected_items.pop_front();
				if (got !== want) begin
					note_failure("result item mismatch");
					show_result("want", want);
					show_result("got ", got);
				end
			end
		end
	end

	// receiver: changing stall patterns plus requested long hold-offs
	initial begin : result_sink
		int hold_left, holds_granted, mode, mode_timer, tick;
		hold_left = 0;
		holds_granted = 0;
		mode = 0;
		mode_timer = 0;
		tick = 0;
		res_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			tick++;
			if (++mode_timer >= 96) begin
				mode_timer = 0;
				mode = $urandom_range(0, 3);
			end
			if (hold_left > 0) begin
				hold_left--;
				res_ch.ready <= 1'b0;
			end else if (holds_granted != holds_asked) begin
				holds_granted++;
				hold_left = HOLD_CYCLES;
				res_ch.ready <= 1'b0;
			end else begin
				case (mode)
					0: res_ch.ready <= 1'b1;
					1: res_ch.ready <= 1'($urandom_range(0, 1));
					2: res_ch.ready <= (tick % 4 == 0);
					default: res_ch.ready <= ($urandom_range(0, 9) != 0);
				endcase
			end
		end
	end

	// watchdog on cycles without any transfer
	initial begin : watchdog
		int idle;
		idle = 0;
		forever begin
			@(posedge clk);
			if (!arst_n || psel || (pkt_ch.valid && pkt_ch.ready) ||
					(res_ch.valid && res_ch.ready))
				idle = 0;
			else
				idle++;
			if (idle >= IDLE_LIMIT) begin
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	// main sequence: reset, directed rows, then randomized phases
	initial begin : main_flow
		int phase_start;
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		pkt_ch.valid <= 1'b0;
		pkt_ch.data_byte <= '0;
		pkt_ch.end_of_packet <= 1'b0;
		cfg_call_code = RST_CALL_CODE;
		cfg_term_id = RST_TERM_ID;
		cfg_term_mask = RST_TERM_MASK;
		clear_packet();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed rows run on the reset register values
		foreach (directed_rows[i]) begin
			send_byte(directed_rows[i].data, directed_rows[i].eop);
			if (directed_rows[i].known)
				expected_items[expected_items.size() - 1].status = directed_rows[i].status;
		end
		wait_idle();

		for (int ph = 1; ph <= 6; ph++) begin
			apply_settings(ph);
			gaps_on = (ph != 2);
			if (ph == 2)
				holds_asked++;
			phase_start = sent_count;
			if (ph == 4) begin
				build_packet(1'b1);
				send_packet();
			end
			while (sent_count - phase_start < PHASE_ITEMS) begin
				build_packet(1'b0);
				send_packet();
			end
			wait_idle();
		end

		if (fail_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
